/* rtl/bpf_pkg.sv */
// ----------------------------------------------------------------------------
// bpf_pkg: background pixel fetch types and constants
// Result kinds, fetch phases and fixed video bus address fields.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int unsigned ADDR_W   = 14;
  localparam int unsigned COLOUR_W = 6;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned NT_SEL_W = 2;
  localparam int unsigned CFG_W    = 2;

  // Register indexes on the config port
  localparam logic REG_NAMETABLE_SELECT  = 1'b0;
  localparam logic REG_BG_PATTERN_SELECT = 1'b1;

  // Request types on the input stream
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Nametable region starts at 0x2000: top two address bits are 2'b10
  localparam logic [1:0] NT_PREFIX   = 2'b10;
  // Attribute table sits at offset 0x3C0 inside a nametable
  localparam logic [3:0] ATTR_PREFIX = 4'b1111;
  // Palette RAM base 0x3F00
  localparam logic [ADDR_W-1:0] PALETTE_BASE = 14'h3F00;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_IGNORE = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TILE = 6'b000010,
    PH_LOW  = 6'b000100,
    PH_HIGH = 6'b001000,
    PH_ATTR = 6'b010000,
    PH_PAL  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_y;
    logic [COORD_W-1:0]  out_x;
    logic [COLOUR_W-1:0] colour_index;
    logic [ADDR_W-1:0]   read_address;
    kind_t               result_kind;
  } result_t;

endpackage

/* rtl/background_pixel_fetch_core.sv */
// ----------------------------------------------------------------------------
// background_pixel_fetch_core: per-pixel background fetch engine
// Turns a pixel request into a chain of video bus reads and a colour index.
// ----------------------------------------------------------------------------
// A pixel request (s_tuser = 0) returns the nametable read address; the user
// then feeds each byte read back as a data word (s_tuser = 1) and gets the
// next address: pattern low plane, pattern high plane, attribute byte,
// palette entry. The data word carrying the palette byte returns the finished
// 6-bit colour (kind 1). Every input word yields exactly one output word.
// A request while a fetch is in progress, or data while idle, returns an
// ignored word (kind 2) and leaves the fetch untouched. The address logic is
// only bit fields and an OR into the palette base, sitting between the input
// handshake and the output register, so one word per clock is sustained
// while s_tready is high. A two-entry output stage (output register plus
// skid) lets the core take a new word while a result still waits downstream;
// s_tready drops only when both entries are full. Config writes apply at the
// next address issued and should be made while the stream is idle.
// ----------------------------------------------------------------------------
module background_pixel_fetch_core
  import bpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_x[7:0], pixel_y[15:8], read_data[23:16]
  input  logic        s_tuser,   // req_type
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_address[13:0], colour_index[19:14],
                                 // out_x[27:20], out_y[35:28], zero[39:36]
  output logic [1:0]  m_tuser    // result_kind
);

  // config registers
  logic [NT_SEL_W-1:0] nametable_select;
  logic                bg_pattern_select;

  // fetch state
  phase_t             phase, phase_next;
  logic [COORD_W-1:0] held_x, held_x_next;
  logic [COORD_W-1:0] held_y, held_y_next;
  logic [BYTE_W-1:0]  tile_number, tile_number_next;
  logic               plane_low_bit, plane_low_bit_next;
  logic [1:0]         pixel_value, pixel_value_next;

  // output stage
  result_t out_word, skid_word, new_word;
  logic    skid_valid;

  logic [COORD_W-1:0] in_x, in_y;
  logic [BYTE_W-1:0]  in_data;
  logic               accept, take;
  logic [1:0]         group;
  logic               plane_bit;

  assign in_x    = s_tdata[7:0];
  assign in_y    = s_tdata[15:8];
  assign in_data = s_tdata[23:16];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;

  // pattern bit of this pixel's column: bit 7 is the leftmost pixel
  assign plane_bit = in_data[~held_x[2:0]];
  // attribute quadrant: two bits per 16x16 area, y half picks the nibble
  assign group = in_data[{held_y[4], held_x[4], 1'b0} +: 2];

  always_comb begin
    phase_next         = phase;
    held_x_next        = held_x;
    held_y_next        = held_y;
    tile_number_next   = tile_number;
    plane_low_bit_next = plane_low_bit;
    pixel_value_next   = pixel_value;

    new_word.result_kind  = KIND_IGNORE;
    new_word.read_address = '0;
    new_word.colour_index = '0;

    case (phase)
      PH_TILE: begin
        if (s_tuser == REQ_DATA) begin
          tile_number_next      = in_data;
          phase_next            = PH_LOW;
          new_word.result_kind  = KIND_READ;
          new_word.read_address = {1'b0, bg_pattern_select, in_data, 1'b0, held_y[2:0]};
        end
      end
      PH_LOW: begin
        if (s_tuser == REQ_DATA) begin
          plane_low_bit_next    = plane_bit;
          phase_next            = PH_HIGH;
          new_word.result_kind  = KIND_READ;
          new_word.read_address = {1'b0, bg_pattern_select, tile_number, 1'b1,
                                   held_y[2:0]};
        end
      end
      PH_HIGH: begin
        if (s_tuser == REQ_DATA) begin
          pixel_value_next      = {plane_bit, plane_low_bit};
          phase_next            = PH_ATTR;
          new_word.result_kind  = KIND_READ;
          new_word.read_address = {NT_PREFIX, nametable_select, ATTR_PREFIX,
                                   held_y[7:5], held_x[7:5]};
        end
      end
      PH_ATTR: begin
        if (s_tuser == REQ_DATA) begin
          phase_next           = PH_PAL;
          new_word.result_kind = KIND_READ;
          // value 0 always reads the universal background entry
          if (pixel_value != 2'd0)
            new_word.read_address = PALETTE_BASE | {{(ADDR_W-4){1'b0}}, group, pixel_value};
          else
            new_word.read_address = PALETTE_BASE;
        end
      end
      PH_PAL: begin
        if (s_tuser == REQ_DATA) begin
          phase_next            = PH_IDLE;
          new_word.result_kind  = KIND_COLOUR;
          new_word.colour_index = in_data[COLOUR_W-1:0];
        end
      end
      default: begin
        // idle, and any stray code behaves as idle
        if (s_tuser == REQ_PIXEL) begin
          held_x_next           = in_x;
          held_y_next           = in_y;
          phase_next            = PH_TILE;
          new_word.result_kind  = KIND_READ;
          new_word.read_address = {NT_PREFIX, nametable_select, in_y[7:3], in_x[7:3]};
        end
      end
    endcase

    new_word.out_x = held_x_next;
    new_word.out_y = held_y_next;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nametable_select  <= '0;
      bg_pattern_select <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NAMETABLE_SELECT:  nametable_select  <= cfg_data[NT_SEL_W-1:0];
        REG_BG_PATTERN_SELECT: bg_pattern_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // fetch state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      held_x        <= '0;
      held_y        <= '0;
      tile_number   <= '0;
      plane_low_bit <= 1'b0;
      pixel_value   <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      held_x        <= held_x_next;
      held_y        <= held_y_next;
      tile_number   <= tile_number_next;
      plane_low_bit <= plane_low_bit_next;
      pixel_value   <= pixel_value_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || take) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || take) begin
      if (skid_valid)
        out_word <= skid_word;
      else if (accept)
        out_word <= new_word;
    end else if (accept) begin
      skid_word <= new_word;
    end
  end

  assign m_tuser = out_word.result_kind;
  assign m_tdata = {4'b0000, out_word.out_y, out_word.out_x, out_word.colour_index,
                    out_word.read_address};

endmodule

/* tb/tb_background_pixel_fetch_core.sv */
// ----------------------------------------------------------------------------
// tb_background_pixel_fetch_core: self-checking bench for the pixel fetch core
// Drives pixel requests and returned bus bytes through the input stream and
// compares every output word, field by field, against an in-bench model of
// the fetch chain. A short directed table comes first, then random fetches
// over several nametable/pattern bank settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_background_pixel_fetch_core;
  import bpf_pkg::*;

  localparam int unsigned RANDOM_WORDS = 400;  // non-ignored words in the random part
  localparam int unsigned PHASE_WORDS  = 50;   // non-ignored words per register setting
  localparam int unsigned STALL_LIMIT  = 2000; // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES  = 120;  // long back-pressure on the output

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;   // pixel_x[7:0], pixel_y[15:8], read_data[23:16]
  logic              s_tuser;   // req_type
  logic              m_tvalid;
  logic              m_tready;
  logic [39:0]       m_tdata;   // read_address[13:0], colour_index[19:14],
                                // out_x[27:20], out_y[35:28], zero[39:36]
  logic [1:0]        m_tuser;   // result_kind

  background_pixel_fetch_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Fetch chain model: mirrors the core's registers and state
  // --------------------------------------------------------------------------
  logic [1:0] nt_sel;
  logic       pat_bank;
  phase_t     fetch_phase;
  logic [7:0] cur_x;
  logic [7:0] cur_y;
  logic [7:0] tile_idx;
  logic       low_bit;
  logic [1:0] pix_val;

  result_t    words_due[$];   // expected output words, oldest first

  int unsigned n_sent;
  int unsigned n_live;        // words that did real work (not ignored)
  int unsigned n_checked;
  int unsigned n_colours;
  int unsigned n_ignored;
  int unsigned n_settings;
  int unsigned n_fail;
  bit          hold_req;      // asks the output side for one long stall

  // Pattern row address for the held tile and pixel row; plane_off 0 or 8
  function automatic logic [13:0] pattern_row(int unsigned plane_off);
    return 14'(32'h1000 * pat_bank + 16 * tile_idx + cur_y[2:0] + plane_off);
  endfunction

  // One input word in, one output word predicted; advances the model state
  function automatic result_t fetch_step(logic req, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] d);
    result_t     r;
    int unsigned nt_base;
    int unsigned sh;
    logic [1:0]  grp;
    r = '0;
    nt_base = 32'h2000 + 32'h0400 * nt_sel;
    if (req == REQ_PIXEL) begin
      if (fetch_phase != PH_IDLE) begin
        r.result_kind = KIND_IGNORE;      // request while busy
      end else begin
        cur_x = x;
        cur_y = y;
        fetch_phase = PH_TILE;
        r.result_kind = KIND_READ;
        r.read_address = 14'(nt_base + 32 * (y >> 3) + (x >> 3));
      end
    end else if (fetch_phase == PH_IDLE) begin
      r.result_kind = KIND_IGNORE;        // stray data
    end else begin
      r.result_kind = KIND_READ;
      sh = 7 - cur_x[2:0];
      case (fetch_phase)
        PH_TILE: begin
          tile_idx = d;
          fetch_phase = PH_LOW;
          r.read_address = pattern_row(0);
        end
        PH_LOW: begin
          low_bit = d[sh];
          fetch_phase = PH_HIGH;
          r.read_address = pattern_row(8);
        end
        PH_HIGH: begin
          pix_val = {d[sh], low_bit};
          fetch_phase = PH_ATTR;
          r.read_address = 14'(nt_base + 960 + 8 * (cur_y >> 5) + (cur_x >> 5));
        end
        PH_ATTR: begin
          // quadrant select: bit 4 of y picks the nibble, bit 4 of x the pair
          grp = 2'(d >> (4 * cur_y[4] + 2 * cur_x[4]));
          fetch_phase = PH_PAL;
          r.read_address = (pix_val != 2'd0) ?
                           14'(PALETTE_BASE + 4 * grp + pix_val) : PALETTE_BASE;
        end
        default: begin
          fetch_phase = PH_IDLE;
          r.result_kind = KIND_COLOUR;
          r.colour_index = d[5:0];
        end
      endcase
    end
    r.out_x = cur_x;
    r.out_y = cur_y;
    return r;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(bit enable);
    int unsigned roll;
    if (!enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  bit src_gaps;

  // Offer one word and return at the edge that accepts it. The expectation is
  // queued up front: only this process feeds the input, so order is fixed.
  task automatic send_word(logic req, logic [7:0] x, logic [7:0] y, logic [7:0] d,
                           bit typed, result_t want);
    result_t     pred;
    int unsigned gap;
    pred = fetch_step(req, x, y, d);
    words_due.push_back(typed ? want : pred);
    if (pred.result_kind != KIND_IGNORE) n_live++;
    n_sent++;
    gap = pick_gap(src_gaps);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {d, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for every outstanding word
  task automatic drain();
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  // Both registers, one write each; the model follows at once since the
  // stream is drained
  task automatic write_regs(logic [1:0] nt, logic bank);
    logic spare;
    spare = 1'($urandom_range(0, 1));   // unused upper bit of the bank write
    cfg_we    <= 1'b1;
    cfg_index <= REG_NAMETABLE_SELECT;
    cfg_data  <= nt;
    @(posedge clk);
    cfg_index <= REG_BG_PATTERN_SELECT;
    cfg_data  <= {spare, bank};
    @(posedge clk);
    cfg_we <= 1'b0;
    nt_sel   = nt;
    pat_bank = bank;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Expected words are typed in where obvious; the rest come
  // from the model.
  // --------------------------------------------------------------------------
  typedef struct {
    logic       req;
    logic [7:0] x, y, d;
    bit         typed;
    kind_t      kind;
    logic [13:0] addr;
    logic [5:0] colour;
    logic [7:0] ox, oy;
  } stim_row_t;

  stim_row_t dir_rows [0:19] = '{
    // data with nothing in flight, straight after reset
    '{REQ_DATA,  8'd0,   8'd0,   8'h5A, 1'b1, KIND_IGNORE, 14'h0,    6'h00, 8'd0,   8'd0},
    // top-left pixel, default nametable
    '{REQ_PIXEL, 8'd0,   8'd0,   8'h00, 1'b1, KIND_READ,   14'h2000, 6'h00, 8'd0,   8'd0},
    // request while busy
    '{REQ_PIXEL, 8'd255, 8'd239, 8'h00, 1'b1, KIND_IGNORE, 14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'hFF, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h80, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h00, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'hFF, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    // palette byte, upper bits dropped
    '{REQ_DATA,  8'd0,   8'd0,   8'hFF, 1'b1, KIND_COLOUR, 14'h0,    6'h3F, 8'd0,   8'd0},
    // bottom-right visible pixel
    '{REQ_PIXEL, 8'd255, 8'd239, 8'h00, 1'b1, KIND_READ,   14'h23BF, 6'h00, 8'd255, 8'd239},
    '{REQ_DATA,  8'd0,   8'd0,   8'h00, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h00, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h00, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    // transparent pixel: universal background, attribute group unused
    '{REQ_DATA,  8'd0,   8'd0,   8'hFF, 1'b1, KIND_READ,   14'h3F00, 6'h00, 8'd255, 8'd239},
    '{REQ_DATA,  8'd0,   8'd0,   8'hC0, 1'b1, KIND_COLOUR, 14'h0,    6'h00, 8'd255, 8'd239},
    // row past the visible area: tile read lands in the attribute area
    '{REQ_PIXEL, 8'd7,   8'd255, 8'h00, 1'b1, KIND_READ,   14'h23E0, 6'h00, 8'd7,   8'd255},
    '{REQ_DATA,  8'd0,   8'd0,   8'hAA, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h01, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'hFF, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h55, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0},
    '{REQ_DATA,  8'd0,   8'd0,   8'h15, 1'b0, KIND_READ,   14'h0,    6'h00, 8'd0,   8'd0}
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    result_t     want;
    logic        req;
    logic [7:0]  x, y, d;
    int unsigned phase_no;
    int unsigned phase_start;
    logic [1:0]  nt;
    logic        bank;

    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_NAMETABLE_SELECT;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_PIXEL;
    m_tready = 1'b0;
    hold_req = 1'b0;
    src_gaps = 1'b1;
    n_sent = 0; n_live = 0; n_checked = 0; n_colours = 0;
    n_ignored = 0; n_settings = 0; n_fail = 0;

    // model reset state
    nt_sel = 2'd0; pat_bank = 1'b0; fetch_phase = PH_IDLE;
    cur_x = '0; cur_y = '0; tile_idx = '0; low_bit = 1'b0; pix_val = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part runs on the reset register values
    foreach (dir_rows[i]) begin
      want = '0;
      want.result_kind  = dir_rows[i].kind;
      want.read_address = dir_rows[i].addr;
      want.colour_index = dir_rows[i].colour;
      want.out_x        = dir_rows[i].ox;
      want.out_y        = dir_rows[i].oy;
      send_word(dir_rows[i].req, dir_rows[i].x, dir_rows[i].y, dir_rows[i].d,
                dir_rows[i].typed, want);
    end

    // random part: one register setting per phase, extremes first. A phase
    // may end mid-fetch, so new settings also land between chain reads.
    phase_start = n_live;
    phase_no = 0;
    while (n_live - phase_start < RANDOM_WORDS) begin
      drain();
      case (phase_no)
        0: begin nt = 2'd3; bank = 1'b1; end
        1: begin nt = 2'd0; bank = 1'b0; end
        2: begin nt = 2'd2; bank = 1'b0; end
        3: begin nt = 2'd1; bank = 1'b1; end
        default: begin
          nt = 2'($urandom_range(0, 3));
          bank = 1'($urandom_range(0, 1));
        end
      endcase
      write_regs(nt, bank);
      src_gaps = ($urandom_range(0, 3) != 0);   // some phases run back to back
      for (int unsigned k = n_live; n_live - k < PHASE_WORDS; ) begin
        // mostly clean fetch chains; now and then a stray word
        if (fetch_phase == PH_IDLE)
          req = ($urandom_range(0, 9) == 0) ? REQ_DATA : REQ_PIXEL;
        else
          req = ($urandom_range(0, 14) == 0) ? REQ_PIXEL : REQ_DATA;
        x = 8'($urandom_range(0, 255));
        y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(240, 255))
                                        : 8'($urandom_range(0, 239));
        d = 8'($urandom_range(0, 255));
        // long output stall once, while words keep coming
        if (phase_no == 2 && n_live - k == 20) hold_req = 1'b1;
        send_word(req, x, y, d, 1'b0, '0);
      end
      phase_no++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input words, checked %0d output words (%0d colours, %0d ignored)",
             n_sent, n_checked, n_colours, n_ignored);
    $display("Register settings used: %0d, field mismatches: %0d", n_settings, n_fail);
    if (n_fail == 0 && words_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and field checks
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
      n_fail++;
    end
  endtask

  initial begin : result_sink
    result_t     want;
    int unsigned stall;
    int unsigned tick;
    bit          quiet;
    stall = 0;
    tick = 0;
    quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (words_due.size() == 0) begin
          $error("output word with none expected: kind 0x%0h data 0x%0h", m_tuser, m_tdata);
          n_fail++;
        end else begin
          want = words_due.pop_front();
          check_field("result_kind",  want.result_kind,  m_tuser);
          check_field("read_address", want.read_address, m_tdata[13:0]);
          check_field("colour_index", want.colour_index, m_tdata[19:14]);
          check_field("out_x",        want.out_x,        m_tdata[27:20]);
          check_field("out_y",        want.out_y,        m_tdata[35:28]);
          check_field("tdata_pad",    0,                 m_tdata[39:36]);
          if (want.result_kind == KIND_COLOUR) n_colours++;
          if (want.result_kind == KIND_IGNORE) n_ignored++;
        end
        n_checked++;
      end
      // every so often switch between gappy and always-ready stretches
      tick++;
      if (tick % 128 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap(!quiet);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no handshake on either side for too long ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/bpf_pkg.sv
rtl/background_pixel_fetch_core.sv
tb/tb_background_pixel_fetch_core.sv
